// File: rtl/core/mst_pkg.sv
// shared types and constants of the marching squares tiler
// no dependencies; imported by every module of the block
package mst_pkg;

    localparam int TILE_COUNT           = 16;
    localparam int TILE_SLOT            = 64;
    localparam int TILE_NUM_W           = 4;
    localparam int TILE_OFF_W           = 6;
    localparam int TILE_ADDR_W          = TILE_NUM_W + TILE_OFF_W;
    localparam int TILE_DEPTH           = TILE_COUNT * TILE_SLOT;
    localparam int PIX_W                = 24;
    localparam int CHAN_W               = 8;
    localparam int COORD_W              = 11;
    localparam int CASE_W               = 4;
    localparam int ROW_W                = 9;
    localparam int CNT_W                = 9;
    localparam int SUM_W                = 10;
    localparam int MAX_CELLS_PER_COLUMN = 256;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [CHAN_W-1:0] THRESHOLD_RESET = 8'd200;
    localparam logic [CNT_W-1:0]  COUNT_RESET     = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_ROW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_COLUMN = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic [CASE_W-1:0]  kase;
        logic [COORD_W-1:0] base_row;
        logic [COORD_W-1:0] base_col;
    } t_paint_cmd;

    typedef struct packed {
        logic                   en;
        logic [TILE_ADDR_W-1:0] addr;
        logic [PIX_W-1:0]       data;
    } t_tile_wr;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   px;
        logic [CASE_W-1:0]  kase;
        logic               last;
    } t_pixel;

endpackage

// File: rtl/core/mst_paint.sv
// tile painter: contour tile store, pixel walker and output pipeline
// depends on mst_pkg
module mst_paint import mst_pkg::*; #(
    parameter int TILE_SIDE = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_paint_cmd i_cmd,
    input  t_tile_wr   i_wr,
    input  logic       i_tready,
    output logic       o_tvalid,
    output t_pixel     o_pixel,
    output logic       o_busy
);

    localparam int XW = $clog2(TILE_SIDE);
    localparam logic [XW-1:0] LAST_IDX = XW'(TILE_SIDE - 1);

    logic [PIX_W-1:0] r_mem [TILE_DEPTH];

    logic             r_gen_active;
    logic [XW-1:0]    r_xi;
    logic [XW-1:0]    r_yi;
    logic [TILE_OFF_W-1:0] r_off;
    t_paint_cmd       r_cmd;

    logic             r_s1_valid;
    logic [COORD_W-1:0] r_s1_row;
    logic [COORD_W-1:0] r_s1_col;
    logic [CASE_W-1:0]  r_s1_kase;
    logic             r_s1_last;
    logic [PIX_W-1:0] r_s1_px;

    logic             r_out_valid;
    t_pixel           r_out;

    logic adv;
    logic issue;

    assign adv   = !r_out_valid || i_tready;
    assign issue = adv && r_gen_active;

    // pixel walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_active <= 1'b0;
        end else if (i_start) begin
            r_gen_active <= 1'b1;
        end else if (issue && r_xi == LAST_IDX && r_yi == LAST_IDX) begin
            r_gen_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xi  <= '0;
            r_yi  <= '0;
            r_off <= '0;
            r_cmd <= i_cmd;
        end else if (issue) begin
            r_off <= r_off + 1'b1;
            if (r_yi == LAST_IDX) begin
                r_yi <= '0;
                r_xi <= r_xi + 1'b1;
            end else begin
                r_yi <= r_yi + 1'b1;
            end
        end
    end

    // tile store, read data registered with the stage
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (issue) begin
            r_s1_px <= r_mem[{r_cmd.kase, r_off}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_row  <= r_cmd.base_row + COORD_W'(r_xi);
            r_s1_col  <= r_cmd.base_col + COORD_W'(r_yi);
            r_s1_kase <= r_cmd.kase;
            r_s1_last <= (r_xi == LAST_IDX) && (r_yi == LAST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= r_gen_active;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.row  <= r_s1_row;
            r_out.col  <= r_s1_col;
            r_out.px   <= r_s1_px;
            r_out.kase <= r_s1_kase;
            r_out.last <= r_s1_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_pixel  = r_out;
    assign o_busy   = r_gen_active;

endmodule

// File: rtl/core/marching_squares_tiler_top.sv
// marching squares tiler top level: grid tracking, case forming, configuration
// depends on mst_pkg and mst_paint
//
// usage
//   slave stream takes one item per transaction; tuser[0] selects a grid sample
//   (0) or a tile pixel load (1). loads are taken back to back, one per cycle,
//   when idle. a sample is reduced to one grid bit; once it closes a cell the
//   block paints that cell's TILE_SIDE x TILE_SIDE tile on the master stream, one
//   pixel per transaction, row-major within the tile, tlast on the final pixel.
//   a sample that closes no cell passes the case state (and the write state at
//   a row end) before the next item is taken; one that closes a cell waits in
//   the paint state until the pixel walker, issuing one tile store read per
//   cycle unless the master stream stalls, has issued its last read.
//   the configuration channel is always ready and must only be written while
//   no result is pending.
//   a stalled master stream holds its pixel and freezes the painter; the next
//   item may still be taken once the last tile read has been issued.
//   reset sets threshold 200, 256 x 256 cells, grid position to the origin;
//   the tile store and the line store hold no reset value.
module marching_squares_tiler_top import mst_pkg::*; #(
    parameter int TILE_SIDE         = 8,
    parameter int MAX_CELLS_PER_ROW = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // red[7:0], green[15:8], blue[23:16], tile_number[27:24], tile_offset[33:28]
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // operation[0]
    input  logic [0:0]           i_s_tuser,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // image_row[10:0], image_column[21:11], out_red[29:22], out_green[37:30],
    // out_blue[45:38], case_index[49:46]
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_CELLS_PER_ROW + 1);
    localparam int LINE_DEPTH = MAX_CELLS_PER_ROW + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CASE  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_PAINT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CHAN_W-1:0] r_dark_threshold;
    logic [CNT_W-1:0]  r_cells_per_row;
    logic [CNT_W-1:0]  r_cells_per_column;

    logic              r_line [LINE_DEPTH];
    logic              r_tl;
    logic              r_tr;
    logic              r_left;
    logic [CW-1:0]     r_point_column;
    logic [ROW_W-1:0]  r_point_row;

    logic              r_bit;
    logic [CW-1:0]     r_c;
    logic [ROW_W-1:0]  r_row;
    logic              r_last_col;
    logic              r_row_end;

    logic [CHAN_W-1:0] in_red, in_green, in_blue;
    logic [TILE_NUM_W-1:0] in_tile_number;
    logic [TILE_OFF_W-1:0] in_tile_offset;
    logic              in_op;
    logic              s_acc;
    logic              acc_sample;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  limit;
    logic              grid_bit;
    logic [CW-1:0]     cols;
    logic [ROW_W-1:0]  rows;
    logic              paint;
    logic              line_we;
    logic [CW-1:0]     line_addr;
    logic              line_data;
    logic [ROW_W-1:0]  row_m1;
    logic [CW-1:0]     col_m1;
    t_paint_cmd        cmd;
    t_tile_wr          tile_wr;
    logic              start;
    logic              paint_busy;
    t_pixel            pixel;

    assign in_red         = i_s_tdata[7:0];
    assign in_green       = i_s_tdata[15:8];
    assign in_blue        = i_s_tdata[23:16];
    assign in_tile_number = i_s_tdata[27:24];
    assign in_tile_offset = i_s_tdata[33:28];
    assign in_op          = i_s_tuser[0];

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign acc_sample = s_acc && (in_op == OP_SAMPLE);

    // mean above threshold <=> sum above 3*threshold+2
    assign sum      = SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue);
    assign limit    = SUM_W'({r_dark_threshold, 1'b0}) + SUM_W'(r_dark_threshold) + SUM_W'(2);
    assign grid_bit = !(sum > limit);

    always_comb begin
        priority if (r_cells_per_row == '0) begin
            cols = CW'(1);
        end else if (r_cells_per_row > CNT_W'(MAX_CELLS_PER_ROW)) begin
            cols = CW'(MAX_CELLS_PER_ROW);
        end else begin
            cols = CW'(r_cells_per_row);
        end
    end

    always_comb begin
        priority if (r_cells_per_column == '0) begin
            rows = ROW_W'(1);
        end else if (r_cells_per_column > CNT_W'(MAX_CELLS_PER_COLUMN)) begin
            rows = ROW_W'(MAX_CELLS_PER_COLUMN);
        end else begin
            rows = r_cells_per_column;
        end
    end

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_threshold   <= THRESHOLD_RESET;
            r_cells_per_row    <= COUNT_RESET;
            r_cells_per_column <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DARK_THRESHOLD:   r_dark_threshold   <= i_cfg_data[CHAN_W-1:0];
                REG_CELLS_PER_ROW:    r_cells_per_row    <= i_cfg_data;
                REG_CELLS_PER_COLUMN: r_cells_per_column <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    assign paint = (r_row != '0) && (r_c != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_sample) n_state = ST_CASE;
            end
            ST_CASE: begin
                if (r_last_col)  n_state = ST_WRITE;
                else if (paint)  n_state = ST_PAINT;
                else             n_state = ST_IDLE;
            end
            ST_WRITE: begin
                n_state = paint ? ST_PAINT : ST_IDLE;
            end
            ST_PAINT: begin
                if (!paint_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch the sample
    always_ff @(posedge i_clk) begin
        if (acc_sample) begin
            r_bit      <= grid_bit;
            r_c        <= r_point_column;
            r_row      <= r_point_row;
            r_last_col <= (r_point_column >= cols);
            r_row_end  <= (r_point_row >= rows);
        end
    end

    // grid position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left         <= 1'b0;
            r_point_column <= '0;
            r_point_row    <= '0;
        end else if (r_state == ST_CASE) begin
            if (r_last_col) begin
                r_left         <= 1'b0;
                r_point_column <= '0;
                r_point_row    <= r_row_end ? '0 : r_row + 1'b1;
            end else begin
                r_left         <= r_bit;
                r_point_column <= r_c + 1'b1;
            end
        end
    end

    // line store of the previous grid row
    assign col_m1    = r_c - 1'b1;
    assign line_we   = ((r_state == ST_CASE) && (r_c != '0)) || (r_state == ST_WRITE);
    assign line_addr = (r_state == ST_WRITE) ? r_c : col_m1;
    assign line_data = (r_state == ST_WRITE) ? r_bit : r_left;

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line[line_addr] <= line_data;
        end
        if (acc_sample) begin
            r_tl <= r_line[CW'(r_point_column - 1'b1)];
            r_tr <= r_line[r_point_column];
        end
    end

    // painter command
    assign row_m1       = r_row - 1'b1;
    assign cmd.kase     = {r_tl, r_tr, r_bit, r_left};
    assign cmd.base_row = COORD_W'(COORD_W'(row_m1) * COORD_W'(TILE_SIDE));
    assign cmd.base_col = COORD_W'(COORD_W'(col_m1) * COORD_W'(TILE_SIDE));
    assign start        = (r_state == ST_CASE) && paint;

    assign tile_wr.en   = s_acc && (in_op == OP_LOAD);
    assign tile_wr.addr = {in_tile_number, in_tile_offset};
    assign tile_wr.data = {in_red, in_green, in_blue};

    mst_paint #(
        .TILE_SIDE (TILE_SIDE)
    ) u_paint (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (cmd),
        .i_wr     (tile_wr),
        .i_tready (i_m_tready),
        .o_tvalid (o_m_tvalid),
        .o_pixel  (pixel),
        .o_busy   (paint_busy)
    );

    assign o_m_tdata = {6'd0, pixel.kase, pixel.px[7:0], pixel.px[15:8], pixel.px[23:16],
                        pixel.col, pixel.row};
    assign o_m_tlast = pixel.last;

endmodule

// File: rtl/core/mst_checker.sv
// port-level checks for the marching squares tiler
// depends on mst_pkg; bound to marching_squares_tiler_top
module mst_checker import mst_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic [0:0]           i_s_tuser,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic                 o_m_tlast,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready
);

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tlast)))
        else $error("stalled output transaction changed");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tuser[0] == OP_SAMPLE) |=> !o_s_tready)
        else $error("ready right after a sample transaction");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tuser[0] == OP_LOAD) |=> o_s_tready)
        else $error("load transaction stalled the input");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[M_TDATA_W-1:50] == '0))
        else $error("output padding bits not zero");

endmodule

bind marching_squares_tiler_top mst_checker u_mst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tuser  (i_s_tuser),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);
